// ----- hdl/rsmd_pkg.sv -----
// rsmd_pkg: shared types, constants and helpers for the rounded signed muldiv block
// no dependencies; imported by every module under hdl

package rsmd_pkg;

   // operation codes
   localparam logic CMD_DIV    = 1'b0;
   localparam logic CMD_MULDIV = 1'b1;

   // saturation mode codes (the unused code behaves as 64-bit mode)
   localparam logic [1:0] MODE_16 = 2'd0;
   localparam logic [1:0] MODE_32 = 2'd1;
   localparam logic [1:0] MODE_64 = 2'd2;

   localparam logic [63:0] MAX16 = 64'h0000_0000_0000_7FFF;
   localparam logic [63:0] MAX32 = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;

   // one quotient bit per division cell
   localparam int DIV_STEPS = 64;

   // data handed from cell to cell along the division chain
   typedef struct packed {
      logic [63:0] num;   // dividend bits still to shift in, quotient bits shift in below
      logic [31:0] rem;   // partial remainder, below the divisor when the divisor is nonzero
      logic [31:0] dvs;   // divisor magnitude
      logic        neg;   // result sign
      logic [1:0]  mode;  // saturation mode
      logic        zero;  // divisor was zero
   } div_type;

   // clamped magnitude and sign headed for the output buffer
   typedef struct packed {
      logic [63:0] mag;
      logic        neg;
   } mag_type;

   // positive maximum of a saturation mode
   function automatic logic [63:0] mode_max(input logic [1:0] mode);
      logic [63:0] lim;
      unique case (mode)
         MODE_16: lim = MAX16;
         MODE_32: lim = MAX32;
         default: lim = MAX64;
      endcase
      return lim;
   endfunction

endpackage

// ----- hdl/rsmd_prep.sv -----
// rsmd_prep: three front stages - operand magnitudes, product, rounding offset
// depends on rsmd_pkg; feeds the first rsmd_div_cell

module rsmd_prep (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic                  cmd,
   input  logic signed [63:0]    dividend,
   input  logic signed [31:0]    factor_a,
   input  logic signed [31:0]    factor_b,
   input  logic signed [31:0]    divisor,
   input  logic [1:0]            result_size,
   output logic                  out_valid,
   output rsmd_pkg::div_type     out_data
);
   import rsmd_pkg::*;

   typedef struct packed {
      logic        cmd;
      logic [63:0] dmag;
      logic [31:0] amag;
      logic [31:0] bmag;
      logic [31:0] vmag;
      logic        neg;
      logic [1:0]  mode;
      logic        zero;
   } mag_stage_type;

   typedef struct packed {
      logic [63:0] num;
      logic [31:0] vmag;
      logic        neg;
      logic [1:0]  mode;
      logic        zero;
   } prod_stage_type;

   logic           s1_valid_ff, s2_valid_ff, s3_valid_ff;
   mag_stage_type  s1_ff, s1_in;
   prod_stage_type s2_ff, s2_in;
   div_type        s3_ff, s3_in;

   logic [63:0] dvd_u;
   logic [31:0] a_u, b_u, v_u;
   logic        dneg;

   // stage 1: magnitudes and signs
   always_comb begin
      dvd_u = dividend;
      a_u   = factor_a;
      b_u   = factor_b;
      v_u   = divisor;
      dneg  = (cmd == CMD_MULDIV) ? (a_u[31] ^ b_u[31]) : dvd_u[63];
      s1_in.cmd  = cmd;
      s1_in.dmag = dvd_u[63] ? (~dvd_u + 64'd1) : dvd_u;
      s1_in.amag = a_u[31] ? (~a_u + 32'd1) : a_u;
      s1_in.bmag = b_u[31] ? (~b_u + 32'd1) : b_u;
      s1_in.vmag = v_u[31] ? (~v_u + 32'd1) : v_u;
      s1_in.zero = (v_u == 32'd0);
      // a zero divisor gives the positive maximum
      s1_in.neg  = (dneg ^ v_u[31]) & (v_u != 32'd0);
      s1_in.mode = result_size;
   end

   // stage 2: product of factor magnitudes or the dividend magnitude
   always_comb begin
      s2_in.num  = (s1_ff.cmd == CMD_MULDIV) ? (64'(s1_ff.amag) * 64'(s1_ff.bmag))
                                             : s1_ff.dmag;
      s2_in.vmag = s1_ff.vmag;
      s2_in.neg  = s1_ff.neg;
      s2_in.mode = s1_ff.mode;
      s2_in.zero = s1_ff.zero;
   end

   // stage 3: add half the divisor for round half away from zero
   always_comb begin
      s3_in.num  = s2_ff.num + {33'd0, s2_ff.vmag[31:1]};
      s3_in.rem  = 32'd0;
      s3_in.dvs  = s2_ff.vmag;
      s3_in.neg  = s2_ff.neg;
      s3_in.mode = s2_ff.mode;
      s3_in.zero = s2_ff.zero;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_ff;

endmodule

// ----- hdl/rsmd_div_cell.sv -----
// rsmd_div_cell: one restoring division step, yields one quotient bit per cell
// depends on rsmd_pkg; chained DIV_STEPS times in the top level

module rsmd_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  rsmd_pkg::div_type     in_data,
   output logic                  out_valid,
   output rsmd_pkg::div_type     out_data
);
   import rsmd_pkg::*;

   logic        valid_ff;
   div_type     data_ff, data_in;
   logic [32:0] trial;
   logic [32:0] diff;
   logic        fits;

   // shift in the next dividend bit and try the subtraction
   always_comb begin
      trial = {in_data.rem, in_data.num[63]};
      diff  = trial - {1'b0, in_data.dvs};
      fits  = (trial >= {1'b0, in_data.dvs});
      data_in     = in_data;
      data_in.rem = fits ? diff[31:0] : trial[31:0];
      data_in.num = {in_data.num[62:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- hdl/rsmd_clamp.sv -----
// rsmd_clamp: saturates the quotient magnitude to the mode maximum
// depends on rsmd_pkg; sits after the last rsmd_div_cell

module rsmd_clamp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  rsmd_pkg::div_type     in_data,
   output logic                  out_valid,
   output rsmd_pkg::mag_type     out_data
);
   import rsmd_pkg::*;

   logic        valid_ff;
   mag_type     data_ff, data_in;
   logic [63:0] limit;

   // zero divisor or overflow takes the limit
   always_comb begin
      limit = mode_max(in_data.mode);
      data_in.neg = in_data.neg;
      if (in_data.zero || (in_data.num > limit)) begin
         data_in.mag = limit;
      end else begin
         data_in.mag = in_data.num;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- hdl/rsmd_outbuf.sv -----
// rsmd_outbuf: applies the sign and holds results in an output register plus a skid slot
// depends on rsmd_pkg; its advance output freezes the whole pipeline when the skid is full

module rsmd_outbuf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  rsmd_pkg::mag_type     in_data,
   output logic                  advance,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [63:0]    rsp_quotient
);
   import rsmd_pkg::*;

   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_q_ff, out_q_in;
   logic        skid_valid_ff, skid_valid_in;
   logic [63:0] skid_q_ff, skid_q_in;
   logic [63:0] signed_q;
   logic        arrive;
   logic        out_free;

   assign advance = ~skid_valid_ff;
   assign arrive  = advance & in_valid;
   assign signed_q = in_data.neg ? (~in_data.mag + 64'd1) : in_data.mag;
   assign out_free = ~out_valid_ff | ~rsp_stall;

   // output register refills from the skid slot first
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_q_in      = out_q_ff;
      skid_valid_in = skid_valid_ff;
      skid_q_in     = skid_q_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_q_in      = skid_q_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in  = arrive;
            out_q_in      = signed_q;
         end
      end else if (arrive) begin
         skid_valid_in = 1'b1;
         skid_q_in     = signed_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_q_ff  <= out_q_in;
      skid_q_ff <= skid_q_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_quotient = out_q_ff;

endmodule

// ----- hdl/rounded_signed_muldiv_saturate_top.sv -----
// rounded_signed_muldiv_saturate_top: pipelined rounded signed multiply-divide with saturation
// depends on rsmd_pkg, rsmd_prep, rsmd_div_cell, rsmd_clamp, rsmd_outbuf
//
// usage:
// - req_ channel: one beat per operation. req_cmd selects dividing req_dividend or
//   dividing req_factor_a * req_factor_b; req_divisor and req_result_size apply to both.
// - rsp_ channel: one beat per request, in request order, carrying rsp_quotient, the
//   quotient rounded half away from zero, clamped to the 16/32/64-bit mode maximum.
//   A zero divisor returns the positive mode maximum.
// - path: from the accepting edge to rsp_valid a beat passes three front stages
//   (magnitudes, product, rounding offset), a chain of 64 division cells that each
//   settle one quotient bit, a clamp stage and the output register.
// - throughput: one beat per cycle unless stalled, set by the one-bit-per-cell chain.
// - stall: a stalled result holds in the output register while the next one drops
//   into a skid slot; once that slot is full the whole pipeline freezes and
//   req_stall rises until the receiver takes a beat.
// - reset: synchronous, clears every valid bit; in-flight beats are dropped.
//   No state survives between operations.

module rounded_signed_muldiv_saturate_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic signed [63:0] req_dividend,
   input  logic signed [31:0] req_factor_a,
   input  logic signed [31:0] req_factor_b,
   input  logic signed [31:0] req_divisor,
   input  logic [1:0]         req_result_size,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_quotient
);
   import rsmd_pkg::*;

   logic    advance;
   logic    chain_valid [0:DIV_STEPS];
   div_type chain_data  [0:DIV_STEPS];
   logic    clamp_valid;
   mag_type clamp_data;

   assign req_stall = ~advance;

   // front stages
   rsmd_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_valid),
      .cmd         (req_cmd),
      .dividend    (req_dividend),
      .factor_a    (req_factor_a),
      .factor_b    (req_factor_b),
      .divisor     (req_divisor),
      .result_size (req_result_size),
      .out_valid   (chain_valid[0]),
      .out_data    (chain_data[0])
   );

   // division chain, one quotient bit per cell
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
      rsmd_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   // saturation
   rsmd_clamp u_clamp (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (chain_valid[DIV_STEPS]),
      .in_data   (chain_data[DIV_STEPS]),
      .out_valid (clamp_valid),
      .out_data  (clamp_data)
   );

   // sign, output register and skid slot
   rsmd_outbuf u_outbuf (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (clamp_valid),
      .in_data      (clamp_data),
      .advance      (advance),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_quotient (rsp_quotient)
   );

endmodule

// ----- sim/rounded_signed_muldiv_saturate_top_tb.sv -----
// rounded_signed_muldiv_saturate_top_tb: self-checking bench for the rounded signed muldiv block
// depends on rsmd_pkg and rounded_signed_muldiv_saturate_top; predicts each quotient in-line

module rounded_signed_muldiv_saturate_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rsmd_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int TAIL_CYCLES = 120;

   typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_HEAVY} sink_mode_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_cmd = CMD_DIV;
   logic signed [63:0] req_dividend = '0;
   logic signed [31:0] req_factor_a = '0;
   logic signed [31:0] req_factor_b = '0;
   logic signed [31:0] req_divisor = '0;
   logic [1:0]         req_result_size = MODE_16;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [63:0] rsp_quotient;

   logic [63:0]   expected_quotients[$];
   int            mismatch_count = 0;
   int            checked_count = 0;
   int            div_beats = 0;
   int            muldiv_beats = 0;
   int            zero_divisor_beats = 0;
   int            idle_cycles = 0;
   int            stall_hold = 0;
   bit            src_gaps = 1'b1;
   sink_mode_type sink_mode = SINK_OPEN;

   rounded_signed_muldiv_saturate_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_dividend    (req_dividend),
      .req_factor_a    (req_factor_a),
      .req_factor_b    (req_factor_b),
      .req_divisor     (req_divisor),
      .req_result_size (req_result_size),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_quotient    (rsp_quotient)
   );

   always #6 clock = ~clock;

   // expected quotient: magnitudes, half-divisor rounding, clamp, then sign
   function automatic logic [63:0] rounded_quotient(input logic cmd, input logic [63:0] dvd,
                                                    input logic [31:0] fa, input logic [31:0] fb,
                                                    input logic [31:0] dvs,
                                                    input logic [1:0] size);
      logic [63:0] ceiling;
      logic [63:0] dvs_mag;
      logic [63:0] dvd_mag;
      logic [63:0] a_mag;
      logic [63:0] b_mag;
      logic [63:0] q;
      logic        dvd_neg;
      case (size)
         MODE_16: ceiling = MAX16;
         MODE_32: ceiling = MAX32;
         default: ceiling = MAX64;
      endcase
      dvs_mag = dvs[31] ? 64'd0 - {{32{1'b1}}, dvs} : {32'd0, dvs};
      if (dvs_mag == 64'd0)
         return ceiling;
      if (cmd == CMD_DIV) begin
         dvd_mag = dvd[63] ? 64'd0 - dvd : dvd;
         dvd_neg = dvd[63];
      end else begin
         a_mag = fa[31] ? 64'd0 - {{32{1'b1}}, fa} : {32'd0, fa};
         b_mag = fb[31] ? 64'd0 - {{32{1'b1}}, fb} : {32'd0, fb};
         dvd_mag = a_mag * b_mag;
         dvd_neg = fa[31] ^ fb[31];
      end
      // sum is at most 2^63 + 2^30, so 64 unsigned bits hold it
      q = (dvd_mag + (dvs_mag >> 1)) / dvs_mag;
      if (q > ceiling)
         q = ceiling;
      if (dvd_neg ^ dvs[31])
         q = 64'd0 - q;
      return q;
   endfunction

   // wide operand: extremes, short values of either sign, or full random
   function automatic logic [63:0] rand_wide();
      logic [63:0] v;
      int          pick;
      pick = $urandom_range(0, 9);
      v = {$urandom, $urandom};
      if (pick == 0) begin
         case ($urandom_range(0, 4))
            0: v = 64'h8000_0000_0000_0000;
            1: v = 64'h7FFF_FFFF_FFFF_FFFF;
            2: v = 64'd0;
            3: v = '1;
            default: v = 64'd1;
         endcase
      end else if (pick < 5) begin
         v = v >> $urandom_range(1, 62);
         if ($urandom_range(0, 1))
            v = 64'd0 - v;
      end
      return v;
   endfunction

   // 32-bit factor with the same shaping
   function automatic logic [31:0] rand_narrow();
      logic [31:0] v;
      int          pick;
      pick = $urandom_range(0, 9);
      v = $urandom;
      if (pick == 0) begin
         case ($urandom_range(0, 4))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'd0;
            3: v = '1;
            default: v = 32'd1;
         endcase
      end else if (pick < 5) begin
         v = v >> $urandom_range(1, 30);
         if ($urandom_range(0, 1))
            v = 32'd0 - v;
      end
      return v;
   endfunction

   // divisor: zero now and then, many small values
   function automatic logic [31:0] rand_divisor();
      logic [31:0] v;
      int          pick;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         v = 32'd0;
      else if (pick < 5)
         v = $urandom_range(1, 8);
      else
         v = rand_narrow();
      if (pick < 5 && $urandom_range(0, 1))
         v = 32'd0 - v;
      return v;
   endfunction

   // idle cycles before a beat: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!src_gaps || r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // drive one request beat and hold it until accepted
   task automatic send_op(input logic cmd, input logic [63:0] dvd, input logic [31:0] fa,
                          input logic [31:0] fb, input logic [31:0] dvs,
                          input logic [1:0] size);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_dividend    <= dvd;
      req_factor_a    <= fa;
      req_factor_b    <= fb;
      req_divisor     <= dvs;
      req_result_size <= size;
      do @(posedge clock); while (req_stall);
   endtask

   // receiver stall: runs of random length, heavy mode stalls more and longer
   always @(posedge clock) begin
      if (sink_mode == SINK_OPEN) begin
         rsp_stall <= 1'b0;
         stall_hold = 0;
      end else if (stall_hold > 0) begin
         stall_hold--;
      end else if ($urandom_range(0, 99) < (sink_mode == SINK_HEAVY ? 55 : 25)) begin
         rsp_stall <= 1'b1;
         stall_hold = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40)
                                                   : $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
         stall_hold = $urandom_range(0, 6);
      end
   end

   // scoreboard: predict on each request beat, compare on each result beat
   always @(posedge clock) begin
      logic [63:0] want;
      if (!reset && req_valid && !req_stall) begin
         expected_quotients.push_back(rounded_quotient(req_cmd, req_dividend, req_factor_a,
                                                       req_factor_b, req_divisor,
                                                       req_result_size));
         if (req_cmd == CMD_DIV)
            div_beats++;
         else
            muldiv_beats++;
         if (req_divisor == 32'd0)
            zero_divisor_beats++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_quotients.size() == 0) begin
            $display("%0t: unexpected result beat, quotient %h", $time, rsp_quotient);
            mismatch_count++;
         end else begin
            want = expected_quotients.pop_front();
            checked_count++;
            if (rsp_quotient !== want) begin
               $display("%0t: quotient mismatch, expected %h actual %h", $time, want,
                        rsp_quotient);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles where neither channel moves a beat
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, expected_quotients.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // zero divisors, extreme operands, rounding midpoints, negative zero, unused mode code
   task automatic test_extremes();
      send_op(CMD_DIV, 64'd100, $urandom, $urandom, 32'd0, MODE_16);
      send_op(CMD_MULDIV, {$urandom, $urandom}, -32'sd9, 32'sd7, 32'd0, MODE_32);
      send_op(CMD_DIV, -64'sd100, $urandom, $urandom, 32'd0, MODE_64);
      send_op(CMD_DIV, -64'sd100, $urandom, $urandom, 32'd0, 2'd3);
      send_op(CMD_DIV, 64'h8000_0000_0000_0000, $urandom, $urandom, 32'd1, MODE_64);
      send_op(CMD_DIV, 64'h8000_0000_0000_0000, $urandom, $urandom, 32'hFFFF_FFFF, MODE_64);
      send_op(CMD_DIV, 64'h8000_0000_0000_0000, $urandom, $urandom, 32'h8000_0000, 2'd3);
      send_op(CMD_DIV, 64'h7FFF_FFFF_FFFF_FFFF, $urandom, $urandom, 32'h8000_0000, MODE_32);
      send_op(CMD_DIV, 64'h7FFF_FFFF_FFFF_FFFF, $urandom, $urandom, 32'd1, MODE_16);
      send_op(CMD_MULDIV, {$urandom, $urandom}, 32'h8000_0000, 32'h8000_0000, 32'd1, MODE_64);
      send_op(CMD_MULDIV, {$urandom, $urandom}, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              MODE_64);
      send_op(CMD_MULDIV, {$urandom, $urandom}, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
              MODE_32);
      send_op(CMD_MULDIV, {$urandom, $urandom}, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd3, MODE_16);
      send_op(CMD_DIV, 64'd5, $urandom, $urandom, 32'd2, MODE_64);
      send_op(CMD_DIV, -64'sd5, $urandom, $urandom, 32'd2, MODE_64);
      send_op(CMD_DIV, 64'd7, $urandom, $urandom, -32'sd2, MODE_32);
      send_op(CMD_DIV, 64'd4, $urandom, $urandom, 32'd3, MODE_16);
      send_op(CMD_DIV, 64'd0, $urandom, $urandom, -32'sd5, MODE_64);
      send_op(CMD_DIV, 64'd1, $urandom, $urandom, -32'sd3, MODE_64);
      send_op(CMD_MULDIV, {$urandom, $urandom}, 32'd0, -32'sd7, 32'd3, MODE_32);
      send_op(CMD_DIV, 64'd65534, $urandom, $urandom, 32'd2, MODE_16);
      send_op(CMD_DIV, -64'sd65535, $urandom, $urandom, 32'd2, MODE_16);
      send_op(CMD_DIV, 64'h8000_0000, $urandom, $urandom, 32'd1, MODE_32);
      send_op(CMD_DIV, -64'sd2147483648, $urandom, $urandom, 32'd1, MODE_32);
   endtask

   // random divides, a quarter of them on or just under a rounding midpoint
   task automatic test_divide(input int beats);
      logic [31:0] dvs;
      logic [63:0] dvd;
      logic [63:0] dvs_mag;
      for (int i = 0; i < beats; i++) begin
         dvs = rand_divisor();
         if ($urandom_range(0, 3) == 0) begin
            dvs_mag = dvs[31] ? 64'd0 - {{32{1'b1}}, dvs} : {32'd0, dvs};
            dvd = 64'($urandom_range(0, 65535)) * dvs_mag + (dvs_mag >> 1)
                  - 64'($urandom_range(0, 1));
            if ($urandom_range(0, 1))
               dvd = 64'd0 - dvd;
         end else begin
            dvd = rand_wide();
         end
         send_op(CMD_DIV, dvd, $urandom, $urandom, dvs, 2'($urandom_range(0, 3)));
      end
   endtask

   // random multiply-divides
   task automatic test_muldiv(input int beats);
      for (int i = 0; i < beats; i++)
         send_op(CMD_MULDIV, {$urandom, $urandom}, rand_narrow(), rand_narrow(),
                 rand_divisor(), 2'($urandom_range(0, 3)));
   endtask

   // both operations interleaved at random
   task automatic test_mixed(input int beats);
      for (int i = 0; i < beats; i++)
         send_op($urandom_range(0, 1) ? CMD_MULDIV : CMD_DIV, rand_wide(), rand_narrow(),
                 rand_narrow(), rand_divisor(), 2'($urandom_range(0, 3)));
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      sink_mode = SINK_LIGHT;
      test_extremes();
      test_divide(450);
      test_muldiv(450);

      // back to back beats into a free-running receiver
      src_gaps = 1'b0;
      sink_mode = SINK_OPEN;
      test_mixed(330);

      // heavy receiver stalls fill the skid slot and freeze the pipeline
      src_gaps = 1'b1;
      sink_mode = SINK_HEAVY;
      test_mixed(200);
      src_gaps = 1'b0;
      test_mixed(200);
      req_valid <= 1'b0;

      sink_mode = SINK_LIGHT;
      while (expected_quotients.size() != 0)
         @(posedge clock);
      sink_mode = SINK_OPEN;
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d divide and %0d multiply-divide beats, %0d with a zero divisor",
               div_beats, muldiv_beats, zero_divisor_beats);
      $display("%0d quotients checked, %0d mismatches", checked_count, mismatch_count);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
